// ----- rtl/hbs_pkg.sv -----
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types, widths, register codes and helpers of the heightmap sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    // fixed field widths
    localparam int DIM_BITS       = 9;
    localparam int COORD_BITS     = 16;
    localparam int WEIGHT_BITS    = 16;
    localparam int HEIGHT_BITS    = 16;
    localparam int POS_BITS       = 8;
    localparam int SCALED_BITS    = DIM_BITS + COORD_BITS;
    localparam int CFG_INDEX_BITS = 2;

    // parameter defaults
    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(256);

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_HEIGHT = CFG_INDEX_BITS'(1);

    // control that travels with an item
    typedef struct packed {
        logic vld;
        logic wr;
    } hbs_ctl_t;

    // zero acts as one, oversize acts as the store size
    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] value,
        input int unsigned         limit
    );
        logic [DIM_BITS-1:0] res;
        if (value == '0)
            res = DIM_BITS'(1);
        else if (32'(value) > limit)
            res = DIM_BITS'(limit);
        else
            res = value;
        return res;
    endfunction

endpackage

// ----- rtl/hbs_ram.sv -----
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/hbs_front.sv -----
// ----------------------------------------------------------------------------
// hbs_front
// Scales u,v into cell and weight, wraps the neighbours and forms addresses.
// Three register stages: scale, cell select, address.
// ----------------------------------------------------------------------------
module hbs_front
    import hbs_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int COL_BITS   = $clog2(MAX_COLS),
    localparam int ROW_BITS   = $clog2(MAX_ROWS),
    localparam int ADDR_BITS  = $clog2(MAX_COLS * MAX_ROWS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          req_type,
    input  logic [POS_BITS-1:0]           write_col,
    input  logic [POS_BITS-1:0]           write_row,
    input  logic signed [HEIGHT_BITS-1:0] write_value,
    input  logic [COORD_BITS-1:0]         coord_u,
    input  logic [COORD_BITS-1:0]         coord_v,
    input  logic [DIM_BITS-1:0]           map_width,
    input  logic [DIM_BITS-1:0]           map_height,
    output hbs_ctl_t                      ctl,
    output logic [ADDR_BITS-1:0]          addr_00,
    output logic [ADDR_BITS-1:0]          addr_10,
    output logic [ADDR_BITS-1:0]          addr_01,
    output logic [ADDR_BITS-1:0]          addr_11,
    output logic [SAMPLE_BITS-1:0]        wdata,
    output logic [WEIGHT_BITS-1:0]        tx,
    output logic [WEIGHT_BITS-1:0]        ty
);

    // stage 1: scaled coordinates
    hbs_ctl_t                      ctl1_reg, ctl1_next;
    logic [SCALED_BITS-1:0]        sx1_reg, sy1_reg;
    logic [POS_BITS-1:0]           col1_reg, row1_reg;
    logic signed [HEIGHT_BITS-1:0] val1_reg;
    logic                          in_range;

    // stage 2: cell and neighbours
    hbs_ctl_t                      ctl2_reg;
    logic [COL_BITS-1:0]           x2_reg, x12_reg, x2_next, x12_next;
    logic [ROW_BITS-1:0]           y2_reg, y12_reg, y2_next, y12_next;
    logic [WEIGHT_BITS-1:0]        tx2_reg, ty2_reg;
    logic [SAMPLE_BITS-1:0]        wval2_reg;
    logic [DIM_BITS-1:0]           xi, yi;
    logic [DIM_BITS:0]             xi_inc, yi_inc;

    // stage 3: addresses
    hbs_ctl_t                      ctl3_reg;
    logic [ADDR_BITS-1:0]          a00_reg, a10_reg, a01_reg, a11_reg;
    logic [ADDR_BITS-1:0]          base0_next, base1_next;
    logic [SAMPLE_BITS-1:0]        wval3_reg;
    logic [WEIGHT_BITS-1:0]        tx3_reg, ty3_reg;

    always_comb
    begin
        in_range      = (32'(write_col) < MAX_COLS) && (32'(write_row) < MAX_ROWS);
        ctl1_next.vld = accept && (req_type || in_range);
        ctl1_next.wr  = !req_type;
    end

    always_comb
    begin
        xi     = sx1_reg[SCALED_BITS-1 -: DIM_BITS];
        yi     = sy1_reg[SCALED_BITS-1 -: DIM_BITS];
        xi_inc = {1'b0, xi} + 1'b1;
        yi_inc = {1'b0, yi} + 1'b1;
        if (ctl1_reg.wr)
        begin
            x2_next  = COL_BITS'(col1_reg);
            y2_next  = ROW_BITS'(row1_reg);
            x12_next = COL_BITS'(col1_reg);
            y12_next = ROW_BITS'(row1_reg);
        end
        else
        begin
            x2_next  = COL_BITS'(xi);
            y2_next  = ROW_BITS'(yi);
            // right and lower neighbours wrap to zero
            x12_next = (xi_inc >= {1'b0, map_width})  ? '0 : COL_BITS'(xi_inc);
            y12_next = (yi_inc >= {1'b0, map_height}) ? '0 : ROW_BITS'(yi_inc);
        end
    end

    always_comb
    begin
        base0_next = ADDR_BITS'(y2_reg)  * ADDR_BITS'(MAX_COLS);
        base1_next = ADDR_BITS'(y12_reg) * ADDR_BITS'(MAX_COLS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sx1_reg  <= SCALED_BITS'(map_width)  * SCALED_BITS'(coord_u);
        sy1_reg  <= SCALED_BITS'(map_height) * SCALED_BITS'(coord_v);
        col1_reg <= write_col;
        row1_reg <= write_row;
        val1_reg <= write_value;

        x2_reg    <= x2_next;
        x12_reg   <= x12_next;
        y2_reg    <= y2_next;
        y12_reg   <= y12_next;
        tx2_reg   <= sx1_reg[WEIGHT_BITS-1:0];
        ty2_reg   <= sy1_reg[WEIGHT_BITS-1:0];
        wval2_reg <= SAMPLE_BITS'(val1_reg);

        a00_reg   <= base0_next + ADDR_BITS'(x2_reg);
        a10_reg   <= base0_next + ADDR_BITS'(x12_reg);
        a01_reg   <= base1_next + ADDR_BITS'(x2_reg);
        a11_reg   <= base1_next + ADDR_BITS'(x12_reg);
        wval3_reg <= wval2_reg;
        tx3_reg   <= tx2_reg;
        ty3_reg   <= ty2_reg;
    end

    assign ctl     = ctl3_reg;
    assign addr_00 = a00_reg;
    assign addr_10 = a10_reg;
    assign addr_01 = a01_reg;
    assign addr_11 = a11_reg;
    assign wdata   = wval3_reg;
    assign tx      = tx3_reg;
    assign ty      = ty3_reg;

    // right neighbour is either the next column or the wrap to zero
    a_x_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl2_reg.vld && !ctl2_reg.wr) |->
            (x12_reg == '0 || x12_reg == COL_BITS'(x2_reg + 1'b1)))
        else $error("right neighbour column neither next nor wrapped");

    // a write keeps one cell for both neighbours
    a_wr_same: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl2_reg.vld && ctl2_reg.wr) |-> (x12_reg == x2_reg && y12_reg == y2_reg))
        else $error("write item split across cells");

endmodule

// ----- rtl/hbs_lerp.sv -----
// ----------------------------------------------------------------------------
// hbs_lerp
// Two-stage linear blend a + trunc((b - a) * t / 2^16), rounded toward zero.
// ----------------------------------------------------------------------------
module hbs_lerp
    import hbs_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic signed [SAMPLE_BITS-1:0] a,
    input  logic signed [SAMPLE_BITS-1:0] b,
    input  logic [WEIGHT_BITS-1:0]        t,
    output logic signed [SAMPLE_BITS-1:0] y
);

    localparam int PW = SAMPLE_BITS + WEIGHT_BITS + 2;

    logic signed [SAMPLE_BITS:0]   d_next;
    logic signed [PW-1:0]          p_next, p_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [PW-1:0]          bias;
    logic signed [PW-1:0]          p_adj;
    logic signed [PW-1:0]          q;
    logic signed [PW-1:0]          sum;
    logic [SAMPLE_BITS-1:0]        y_next, y_reg;

    always_comb
    begin
        d_next = {b[SAMPLE_BITS-1], b} - {a[SAMPLE_BITS-1], a};
        p_next = PW'(d_next) * PW'($signed({1'b0, t}));
    end

    always_comb
    begin
        bias   = PW'((1 << WEIGHT_BITS) - 1);
        // negative products get the bias so the shift truncates toward zero
        p_adj  = p_reg[PW-1] ? (p_reg + bias) : p_reg;
        q      = p_adj >>> WEIGHT_BITS;
        sum    = PW'(a_reg) + q;
        y_next = sum[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        a_reg <= a;
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

// ----- rtl/heightmap_bilinear_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_unit
// Throughput: one item per cycle; busy never rises and results cannot stall.
// A sample item's result is registered through scale, cell, address, memory
// read, then two blends along x in parallel and one along y, before it strobes.
// Write items give no result; the store is written once the item leaves the address stage.
// Reset clears the valid pipeline and sets map_width, map_height to 256 or the store size.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_unit
    import hbs_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [POS_BITS-1:0]           write_col,
    input  logic [POS_BITS-1:0]           write_row,
    input  logic signed [HEIGHT_BITS-1:0] write_value,
    input  logic [COORD_BITS-1:0]         coord_u,
    input  logic [COORD_BITS-1:0]         coord_v,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [DIM_BITS-1:0]           cfg_data,
    output logic                          result_valid,
    output logic signed [HEIGHT_BITS-1:0] sampled_height
);

    localparam int ADDR_BITS = $clog2(MAX_COLS * MAX_ROWS);
    localparam int DEPTH     = MAX_COLS * MAX_ROWS;

    logic [DIM_BITS-1:0]    width_reg, height_reg;
    logic                   accept;
    hbs_ctl_t               ctl3;
    logic [ADDR_BITS-1:0]   addr_00, addr_10, addr_01, addr_11;
    logic [SAMPLE_BITS-1:0] wdata;
    logic [WEIGHT_BITS-1:0] tx3, ty3;
    logic                   we;
    logic [SAMPLE_BITS-1:0] q00, q10, q01, q11;
    logic [WEIGHT_BITS-1:0] tx4_reg, ty4_reg, ty5_reg, ty6_reg;
    logic                   v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic signed [SAMPLE_BITS-1:0] top6, bot6, res8;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clamp_dim(DIM_RESET, MAX_COLS);
            height_reg <= clamp_dim(DIM_RESET, MAX_ROWS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:  width_reg  <= clamp_dim(cfg_data, MAX_COLS);
                REG_MAP_HEIGHT: height_reg <= clamp_dim(cfg_data, MAX_ROWS);
                default:        ;
            endcase
        end
    end

    hbs_front #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req_type),
        .write_col   (write_col),
        .write_row   (write_row),
        .write_value (write_value),
        .coord_u     (coord_u),
        .coord_v     (coord_v),
        .map_width   (width_reg),
        .map_height  (height_reg),
        .ctl         (ctl3),
        .addr_00     (addr_00),
        .addr_10     (addr_10),
        .addr_01     (addr_01),
        .addr_11     (addr_11),
        .wdata       (wdata),
        .tx          (tx3),
        .ty          (ty3)
    );

    // four copies of the store, one per corner, written together
    assign we = ctl3.vld && ctl3.wr;

    hbs_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_00 (
        .clk(clk), .we(we), .waddr(addr_00), .wdata(wdata),
        .raddr(addr_00), .rdata(q00)
    );

    hbs_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_10 (
        .clk(clk), .we(we), .waddr(addr_00), .wdata(wdata),
        .raddr(addr_10), .rdata(q10)
    );

    hbs_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_01 (
        .clk(clk), .we(we), .waddr(addr_00), .wdata(wdata),
        .raddr(addr_01), .rdata(q01)
    );

    hbs_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_11 (
        .clk(clk), .we(we), .waddr(addr_00), .wdata(wdata),
        .raddr(addr_11), .rdata(q11)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= ctl3.vld && !ctl3.wr;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tx4_reg <= tx3;
        ty4_reg <= ty3;
        ty5_reg <= ty4_reg;
        ty6_reg <= ty5_reg;
    end

    hbs_lerp #(.SAMPLE_BITS(SAMPLE_BITS)) u_lerp_top (
        .clk (clk),
        .a   ($signed(q00)),
        .b   ($signed(q10)),
        .t   (tx4_reg),
        .y   (top6)
    );

    hbs_lerp #(.SAMPLE_BITS(SAMPLE_BITS)) u_lerp_bot (
        .clk (clk),
        .a   ($signed(q01)),
        .b   ($signed(q11)),
        .t   (tx4_reg),
        .y   (bot6)
    );

    hbs_lerp #(.SAMPLE_BITS(SAMPLE_BITS)) u_lerp_fin (
        .clk (clk),
        .a   (top6),
        .b   (bot6),
        .t   (ty6_reg),
        .y   (res8)
    );

    assign result_valid   = v8_reg;
    assign sampled_height = HEIGHT_BITS'(res8);

    // every result traces back to an earlier accepted sample item
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && req_type, 8))
        else $error("result without a matching sample item");

    // write items never produce a result
    a_wr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !req_type) |=> ##7 !result_valid)
        else $error("write item produced a result");

    // map size registers stay within the store
    a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg != '0 && 32'(width_reg) <= MAX_COLS &&
         height_reg != '0 && 32'(height_reg) <= MAX_ROWS))
        else $error("map size register out of range");

endmodule
